@@ hw/rtl/lfp_pkg.sv @@
package lfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIST_HI_W  = 7;
  localparam int unsigned INDEX_W    = 5;
  localparam int unsigned FIELD16_W  = 16;
  localparam int unsigned POINT_BASE = 7;

  typedef enum logic [1:0] {
    CFG_FIRST_HEADER  = 2'd0,
    CFG_SECOND_HEADER = 2'd1,
    CFG_LENGTH_CODE   = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_EMIT_PTS,
    ST_EMIT_ERR
  } lfp_state_e;

  typedef enum logic [1:0] {
    PH_DIST_HI,
    PH_DIST_LO,
    PH_STRENGTH
  } pt_phase_e;

  typedef struct packed {
    logic [DIST_HI_W-1:0] dist_hi;
    logic [BYTE_W-1:0]    dist_lo;
    logic [BYTE_W-1:0]    strength;
  } point_t;

  typedef struct packed {
    logic   shift;
    point_t point;
  } chain_ctrl_t;

endpackage

@@ hw/rtl/lfp_if.sv @@
interface lfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [4:0]  point_index;
  logic [14:0] distance;
  logic [7:0]  strength;
  logic [15:0] scan_speed;
  logic [15:0] start_angle;
  logic [15:0] end_angle;
  logic        last;

  modport source (
    output valid, output frame_ok, output point_index, output distance,
    output strength, output scan_speed, output start_angle, output end_angle,
    output last, input ready
  );
  modport sink (
    input valid, input frame_ok, input point_index, input distance,
    input strength, input scan_speed, input start_angle, input end_angle,
    input last, output ready
  );
endinterface

@@ hw/rtl/lfp_cell.sv @@
module lfp_cell
  import lfp_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  point_t data_i,
  output point_t data_o
);

  point_t data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/lfp_seq.sv @@
module lfp_seq
  import lfp_pkg::*;
#(
  parameter int unsigned POINT_COUNT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  lfp_in_if.sink            in_if,
  lfp_out_if.source         out_if,
  input  point_t            head_i,
  output chain_ctrl_t       ctrl_o
);

  localparam int unsigned FRAME_LEN  = 12 + 3 * POINT_COUNT;
  localparam int unsigned POS_W      = $clog2(FRAME_LEN);
  localparam int unsigned IDX_W      = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int unsigned POINTS_END = POINT_BASE + 3 * POINT_COUNT;
  localparam int unsigned END_HI_POS = POINTS_END + 2;
  localparam int unsigned END_LO_POS = POINTS_END + 3;
  localparam int unsigned CHECK_POS  = POINTS_END + 4;

  lfp_state_e state_q, state_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [BYTE_W-1:0]    sum_q, sum_d;
  pt_phase_e            phase_q, phase_d;
  logic [FIELD16_W-1:0] speed_q, speed_d;
  logic [FIELD16_W-1:0] start_q, start_d;
  logic [BYTE_W-1:0]    end_hi_q, end_hi_d;
  logic [FIELD16_W-1:0] end_q, end_d;
  logic [DIST_HI_W-1:0] dist_hi_q, dist_hi_d;
  logic [BYTE_W-1:0]    dist_lo_q, dist_lo_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [BYTE_W-1:0]    first_hdr_q, second_hdr_q, length_q;

  logic              in_fire;
  logic              out_fire;
  logic              in_points;
  logic              last_point;
  logic              check_good;
  logic              check_byte;
  logic [BYTE_W-1:0] b;

  assign b          = in_if.rx_byte;
  assign in_fire    = in_if.valid && in_if.ready;
  assign out_fire   = out_if.valid && out_if.ready;
  assign in_points  = (pos_q >= POS_W'(POINT_BASE)) && (pos_q < POS_W'(POINTS_END));
  assign last_point = (idx_q == IDX_W'(POINT_COUNT - 1));
  assign check_byte = (pos_q == POS_W'(CHECK_POS));
  assign check_good = (sum_q == b);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_hdr_q  <= '0;
      second_hdr_q <= '0;
      length_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_HEADER:  first_hdr_q  <= cfg_data_i;
        CFG_SECOND_HEADER: second_hdr_q <= cfg_data_i;
        CFG_LENGTH_CODE:   length_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RECV: begin
        if (in_fire && check_byte) begin
          state_d = check_good ? ST_EMIT_PTS : ST_EMIT_ERR;
        end
      end
      ST_EMIT_PTS: begin
        if (out_fire && last_point) begin
          state_d = ST_RECV;
        end
      end
      ST_EMIT_ERR: begin
        if (out_fire) begin
          state_d = ST_RECV;
        end
      end
      default: state_d = ST_RECV;
    endcase
  end

  // Handshake, result and chain outputs.
  always_comb begin
    in_if.ready        = 1'b0;
    out_if.valid       = 1'b0;
    out_if.frame_ok    = 1'b0;
    out_if.point_index = '0;
    out_if.distance    = '0;
    out_if.strength    = '0;
    out_if.scan_speed  = '0;
    out_if.start_angle = '0;
    out_if.end_angle   = '0;
    out_if.last        = 1'b0;
    ctrl_o.shift       = 1'b0;
    ctrl_o.point       = '{dist_hi: dist_hi_q, dist_lo: dist_lo_q, strength: b};
    case (state_q)
      ST_RECV: begin
        in_if.ready  = 1'b1;
        ctrl_o.shift = in_fire && in_points && (phase_q == PH_STRENGTH);
      end
      ST_EMIT_PTS: begin
        out_if.valid       = 1'b1;
        out_if.frame_ok    = 1'b1;
        out_if.point_index = INDEX_W'(idx_q);
        out_if.distance    = {head_i.dist_hi, head_i.dist_lo};
        out_if.strength    = head_i.strength;
        out_if.scan_speed  = speed_q;
        out_if.start_angle = start_q;
        out_if.end_angle   = end_q;
        out_if.last        = last_point;
        ctrl_o.shift       = out_fire;
      end
      ST_EMIT_ERR: begin
        out_if.valid = 1'b1;
        out_if.last  = 1'b1;
      end
      default: ;
    endcase
  end

  // Byte parser datapath.
  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    phase_d   = phase_q;
    speed_d   = speed_q;
    start_d   = start_q;
    end_hi_d  = end_hi_q;
    end_d     = end_q;
    dist_hi_d = dist_hi_q;
    dist_lo_d = dist_lo_q;
    idx_d     = idx_q;

    if (state_q == ST_EMIT_PTS && out_fire) begin
      idx_d = idx_q + IDX_W'(1);
    end

    if (in_fire) begin
      pos_d   = pos_q + POS_W'(1);
      sum_d   = sum_q + b;
      phase_d = PH_DIST_HI;
      if (pos_q == POS_W'(0)) begin
        if (b != first_hdr_q) begin
          pos_d = '0;
          sum_d = '0;
        end
      end else if (pos_q == POS_W'(1)) begin
        if (b != second_hdr_q) begin
          pos_d = '0;
          sum_d = '0;
        end
      end else if (pos_q == POS_W'(2)) begin
        if (b != length_q) begin
          pos_d = '0;
          sum_d = '0;
        end
      end else if (pos_q == POS_W'(3)) begin
        speed_d = {b, speed_q[BYTE_W-1:0]};
      end else if (pos_q == POS_W'(4)) begin
        speed_d = {speed_q[FIELD16_W-1:BYTE_W], b};
      end else if (pos_q == POS_W'(5)) begin
        start_d = {b, start_q[BYTE_W-1:0]};
      end else if (pos_q == POS_W'(6)) begin
        start_d = {start_q[FIELD16_W-1:BYTE_W], b};
      end else if (in_points) begin
        case (phase_q)
          PH_DIST_HI: begin
            dist_hi_d = b[DIST_HI_W-1:0];
            phase_d   = PH_DIST_LO;
          end
          PH_DIST_LO: begin
            dist_lo_d = b;
            phase_d   = PH_STRENGTH;
          end
          default: phase_d = PH_DIST_HI;
        endcase
      end else if (pos_q == POS_W'(POINTS_END) || pos_q == POS_W'(POINTS_END + 1)) begin
        // The two reserved bytes only count toward the checksum.
      end else if (pos_q == POS_W'(END_HI_POS)) begin
        end_hi_d = b;
      end else if (pos_q == POS_W'(END_LO_POS)) begin
        end_d = {end_hi_q, b};
      end else if (check_byte) begin
        pos_d = '0;
        sum_d = '0;
        idx_d = '0;
        if (!check_good) begin
          speed_d  = '0;
          start_d  = '0;
          end_hi_d = '0;
          end_d    = '0;
        end
      end else begin
        pos_d = '0;
        sum_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RECV;
      pos_q    <= '0;
      sum_q    <= '0;
      phase_q  <= PH_DIST_HI;
      speed_q  <= '0;
      start_q  <= '0;
      end_hi_q <= '0;
      end_q    <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      phase_q  <= phase_d;
      speed_q  <= speed_d;
      start_q  <= start_d;
      end_hi_q <= end_hi_d;
      end_q    <= end_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_hi_q <= dist_hi_d;
    dist_lo_q <= dist_lo_d;
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input accepted while results are pending");

  a_emit_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RECV) |-> (pos_q == '0 && sum_q == '0))
    else $error("parser not rewound during result output");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_if.last) |=> (state_q == ST_RECV))
    else $error("results continue after the last one");

  a_phase_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_DIST_HI) |-> in_points)
    else $error("point byte phase outside the point region");

  a_check_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && check_byte) |=> out_if.valid)
    else $error("checksum byte produced no result");
`endif

endmodule

@@ hw/rtl/lidar_frame_parser_top.sv @@
// Channel   Direction  Payload
// in_if     sink       rx_byte
// out_if    source     frame_ok, point_index, distance, strength, scan_speed,
//                      start_angle, end_angle, last
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// Each byte offered in ST_RECV is taken; a byte with no result is done at once.
// After the checksum byte the block emits POINT_COUNT point transactions, or one
// error transaction, at one per cycle as the chain of point cells shifts toward
// its head; input is held off until the last result transaction completes.
// A stalled output simply freezes the chain. Reset is asynchronous, active low.
module lidar_frame_parser_top
  import lfp_pkg::*;
#(
  parameter int unsigned POINT_COUNT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  lfp_in_if.sink            in_if,
  lfp_out_if.source         out_if
);

  chain_ctrl_t ctrl;
  point_t      chain [POINT_COUNT];

  lfp_seq #(
    .POINT_COUNT(POINT_COUNT)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if),
    .head_i     (chain[0]),
    .ctrl_o     (ctrl)
  );

  for (genvar i = 0; i < POINT_COUNT; i++) begin : g_cell
    point_t cell_in;
    if (i == POINT_COUNT - 1) begin : g_tail
      assign cell_in = ctrl.point;
    end else begin : g_body
      assign cell_in = chain[i+1];
    end
    lfp_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl.shift),
      .data_i  (cell_in),
      .data_o  (chain[i])
    );
  end

endmodule
